### hw/rtl/i2da_pkg.sv
// ----------------------------------------------------------------------------
// i2da_pkg: shared types and constants for the integer to decimal ASCII block
// Holds the widths, the character codes and the data record that is passed
// from one conversion cell to the next.
// ----------------------------------------------------------------------------
package i2da_pkg;

	// Input word width and number of decimal digits it can produce.
	localparam int unsigned BIN_W      = 32;
	localparam int unsigned NUM_DIGITS = 10;
	localparam int unsigned BCD_W      = 4 * NUM_DIGITS;

	// Stream payload widths.
	localparam int unsigned CHAR_W      = 6;
	localparam int unsigned COUNT_W     = 4;
	localparam int unsigned IN_TDATA_W  = 32;
	localparam int unsigned OUT_TDATA_W = 16;

	// ASCII codes, truncated to the six bits that are carried.
	localparam logic [CHAR_W-1:0] CH_MINUS = 6'd45;
	localparam logic [CHAR_W-1:0] CH_ZERO  = 6'd48;

	// Record that travels down the chain of double-dabble cells.
	typedef struct packed {
		logic [BCD_W-1:0] bcd;   // decimal digits built so far
		logic [BIN_W-1:0] bin;   // magnitude bits still to shift in, MSB first
		logic             neg;   // the original value was negative
	} cell_data_t;

endpackage

### hw/rtl/i2da_cell.sv
// ----------------------------------------------------------------------------
// i2da_cell: one double-dabble step
// Adds three to every BCD digit of five or more, then shifts the next
// binary bit into the BCD word. Registered, advancing on a shared enable.
// ----------------------------------------------------------------------------
module i2da_cell (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 en,
	input  logic                 in_valid,
	input  i2da_pkg::cell_data_t in_data,
	output logic                 out_valid,
	output i2da_pkg::cell_data_t out_data
);
	import i2da_pkg::*;

	logic [BCD_W-1:0] adj;
	cell_data_t       nxt;
	logic             valid_q;
	cell_data_t       data_q;

	// Correct each digit independently before the shift.
	always_comb begin
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (in_data.bcd[4*i +: 4] >= 4'd5) begin
				adj[4*i +: 4] = in_data.bcd[4*i +: 4] + 4'd3;
			end else begin
				adj[4*i +: 4] = in_data.bcd[4*i +: 4];
			end
		end
		nxt.bcd = {adj[BCD_W-2:0], in_data.bin[BIN_W-1]};
		nxt.bin = {in_data.bin[BIN_W-2:0], 1'b0};
		nxt.neg = in_data.neg;
	end

	// Valid flag of this cell.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	// Payload register.
	always_ff @(posedge clk) begin
		if (en) begin
			data_q <= nxt;
		end
	end

	assign out_valid = valid_q;
	assign out_data  = data_q;

endmodule

### hw/rtl/i2da_ser.sv
// ----------------------------------------------------------------------------
// i2da_ser: character serializer
// Takes the finished BCD word, drops leading zeros and sends the sign and
// the digits one character per beat, most significant first.
// ----------------------------------------------------------------------------
module i2da_ser (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	input  i2da_pkg::cell_data_t          in_data,
	output logic                          in_ready,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [i2da_pkg::CHAR_W-1:0]   out_char,
	output logic                          out_last,
	output logic [i2da_pkg::COUNT_W-1:0]  out_count
);
	import i2da_pkg::*;

	logic                 busy_q;
	logic                 sign_q;
	logic [COUNT_W-1:0]   rem_q;
	logic [COUNT_W-1:0]   total_q;
	logic [BCD_W-1:0]     dig_q;

	logic                 take;
	logic                 last_beat;
	logic                 load;
	logic [COUNT_W-1:0]   nd;
	logic [COUNT_W-1:0]   lead_zeros;
	logic [BCD_W-1:0]     aligned;

	// Number of significant digits, at least one so that zero prints.
	always_comb begin
		nd = COUNT_W'(1);
		for (int i = 0; i < NUM_DIGITS; i++) begin
			if (in_data.bcd[4*i +: 4] != 4'd0) begin
				nd = COUNT_W'(i + 1);
			end
		end
		lead_zeros = COUNT_W'(NUM_DIGITS) - nd;
		aligned    = in_data.bcd << {lead_zeros, 2'b00};
	end

	assign take      = busy_q && out_ready;
	assign last_beat = !sign_q && (rem_q == COUNT_W'(1));
	assign in_ready  = !busy_q || (take && last_beat);
	assign load      = in_valid && in_ready;

	// Busy while characters of a number are pending.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
		end else if (load) begin
			busy_q <= 1'b1;
		end else if (take && last_beat) begin
			busy_q <= 1'b0;
		end
	end

	// Digit shift register, sign flag and counters.
	always_ff @(posedge clk) begin
		if (load) begin
			sign_q  <= in_data.neg;
			rem_q   <= nd;
			total_q <= nd + COUNT_W'(in_data.neg);
			dig_q   <= aligned;
		end else if (take) begin
			if (sign_q) begin
				sign_q <= 1'b0;
			end else begin
				dig_q <= {dig_q[BCD_W-5:0], 4'd0};
				rem_q <= rem_q - COUNT_W'(1);
			end
		end
	end

	// Output beat straight from the registers.
	assign out_valid = busy_q;
	assign out_char  = sign_q ? CH_MINUS : (CH_ZERO + {2'b00, dig_q[BCD_W-1 -: 4]});
	assign out_last  = last_beat;
	assign out_count = last_beat ? total_q : '0;

endmodule

### hw/rtl/int32_to_decimal_ascii_top.sv
// ----------------------------------------------------------------------------
// int32_to_decimal_ascii_top: signed 32-bit integer to decimal ASCII text
// Converts each input word through a chain of double-dabble cells and sends
// its text one character per beat.
// ----------------------------------------------------------------------------
// Usage:
//   The slave stream takes one signed 32-bit value per beat. The master stream
//   sends its decimal text, most significant character first: a minus sign
//   for negative values, then the digits with no leading zeros (zero gives a
//   single 0). The final character of a number has tlast high and carries the
//   character count of the number; the count is zero on other beats.
//   Each input beat is registered in turn by the 32 cells of the conversion
//   chain, the first of which registers the input beat itself, and is then
//   loaded into the serializer.
//   Throughput: one character per cycle while the receiver is ready; a number
//   has 1 to 11 characters, and the serializer port sets the rate. Input beats
//   are taken one per cycle while the last cell is empty or is drained.
//   Reset clears all valid flags; no beats are in flight afterwards.
//   When the receiver stalls, the current character holds and the chain
//   stops only once its last cell holds a finished value.
// ----------------------------------------------------------------------------
module int32_to_decimal_ascii_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 s_axis_tvalid,
	output logic                                 s_axis_tready,
	input  logic [i2da_pkg::IN_TDATA_W-1:0]      s_axis_tdata,  // [31:0] value
	output logic                                 m_axis_tvalid,
	input  logic                                 m_axis_tready,
	output logic [i2da_pkg::OUT_TDATA_W-1:0]     m_axis_tdata,  // [5:0] character,
	                                                            // [9:6] char_count
	output logic                                 m_axis_tlast
);
	import i2da_pkg::*;

	cell_data_t         stage [0:BIN_W];
	logic [BIN_W:0]     vld;
	logic               adv;
	logic               ser_ready;
	logic               in_neg;
	logic [CHAR_W-1:0]  ch;
	logic [COUNT_W-1:0] cnt;

	// Magnitude of the input; the minimum value wraps to 2^31 unsigned.
	assign in_neg       = s_axis_tdata[BIN_W-1];
	assign stage[0].neg = in_neg;
	assign stage[0].bin = in_neg ? (BIN_W'(0) - s_axis_tdata) : s_axis_tdata;
	assign stage[0].bcd = '0;
	assign vld[0]       = s_axis_tvalid;

	// The chain moves whenever its last cell is empty or is drained.
	assign adv           = !vld[BIN_W] || ser_ready;
	assign s_axis_tready = adv;

	// One double-dabble cell per input bit.
	for (genvar g = 0; g < BIN_W; g++) begin : g_cell
		i2da_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.en        (adv),
			.in_valid  (vld[g]),
			.in_data   (stage[g]),
			.out_valid (vld[g+1]),
			.out_data  (stage[g+1])
		);
	end

	// Character serializer.
	i2da_ser u_ser (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (vld[BIN_W]),
		.in_data   (stage[BIN_W]),
		.in_ready  (ser_ready),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_char  (ch),
		.out_last  (m_axis_tlast),
		.out_count (cnt)
	);

	assign m_axis_tdata = {(OUT_TDATA_W - CHAR_W - COUNT_W)'(0), cnt, ch};

endmodule

### tb/int32_to_decimal_ascii_top_test.sv
// ----------------------------------------------------------------------------
// int32_to_decimal_ascii_top_test: self-checking bench for the decimal text
// Sends signed 32-bit values through the slave stream and checks every
// character beat on the master stream against decimal text worked out here,
// with random gaps on both sides, a long receiver hold-off and a full drain.
// ----------------------------------------------------------------------------
module int32_to_decimal_ascii_top_test;

	import i2da_pkg::*;

	// One character beat of the text.
	typedef struct packed {
		logic [CHAR_W-1:0]  code;
		logic               last;
		logic [COUNT_W-1:0] count;
	} text_beat_t;

	// One value to send, optionally only after all text has come back.
	typedef struct packed {
		logic [IN_TDATA_W-1:0] value;
		logic                  drain_first;
	} value_item_t;

	localparam int IDLE_PCT       = 34;
	localparam int HOLD_AT        = 25;    // values accepted before the hold-off
	localparam int HOLD_CYCLES    = 400;
	localparam int BUSY_A_LO      = 20;    // sender offers without gaps here
	localparam int BUSY_A_HI      = 70;
	localparam int BUSY_B_LO      = 90;    // neither side idles here
	localparam int BUSY_B_HI      = 120;
	localparam int RANDOM_VALUES  = 110;
	localparam int SETTLE_CYCLES  = 60;
	localparam int WATCHDOG_LIMIT = 3000;

	logic                   clk = 1'b0;
	logic                   arst_n = 1'b0;
	logic                   s_axis_tvalid = 1'b0;
	logic                   s_axis_tready;
	logic [IN_TDATA_W-1:0]  s_axis_tdata = '0;   // [31:0] value
	logic                   m_axis_tvalid;
	logic                   m_axis_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_axis_tdata;        // [5:0] character, [9:6] char_count
	logic                   m_axis_tlast;

	value_item_t value_queue [$];
	text_beat_t  expected_text [$];
	int          accepted_values = 0;
	logic        text_drained = 1'b1;
	int          mismatches = 0;
	int          hold_left = 0;
	logic        hold_done = 1'b0;
	int          quiet_cycles = 0;

	int32_to_decimal_ascii_top i_dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Work out the decimal text of one value and queue its character beats.
	function automatic void expand_decimal(input logic [IN_TDATA_W-1:0] value);
		logic [3:0]  digit_buf [NUM_DIGITS];
		logic [31:0] mag;
		logic        neg;
		int          n_digits;
		int          total;
		text_beat_t  beat;
		neg = value[31];
		// The magnitude is taken as unsigned, so the minimum value needs no care.
		mag = neg ? (32'd0 - value) : value;
		n_digits = 0;
		do begin
			if (n_digits < NUM_DIGITS) begin
				digit_buf[n_digits] = 4'(mag % 10);
				n_digits++;
			end
			mag = mag / 10;
		end while (mag != 0);
		total = n_digits + (neg ? 1 : 0);
		if (neg) begin
			beat.code  = CH_MINUS;
			beat.last  = 1'b0;
			beat.count = '0;
			expected_text.push_back(beat);
		end
		for (int i = n_digits - 1; i >= 0; i--) begin
			beat.code  = CH_ZERO + CHAR_W'(digit_buf[i]);
			beat.last  = (i == 0);
			beat.count = (i == 0) ? COUNT_W'(total) : '0;
			expected_text.push_back(beat);
		end
	endfunction

	// Sender: offers queued values, with random gaps outside the busy windows.
	always @(posedge clk or negedge arst_n) begin
		value_item_t next_item;
		if (!arst_n) begin
			s_axis_tvalid <= 1'b0;
			s_axis_tdata  <= '0;
		end else if (!s_axis_tvalid || s_axis_tready) begin
			if (value_queue.size() == 0) begin
				s_axis_tvalid <= 1'b0;
			end else if (value_queue[0].drain_first && (s_axis_tvalid || !text_drained)) begin
				s_axis_tvalid <= 1'b0;
			end else if (!(accepted_values >= BUSY_A_LO && accepted_values < BUSY_A_HI) &&
			             !(accepted_values >= BUSY_B_LO && accepted_values < BUSY_B_HI) &&
			             $urandom_range(0, 99) < IDLE_PCT) begin
				s_axis_tvalid <= 1'b0;
			end else begin
				next_item = value_queue.pop_front();
				s_axis_tvalid <= 1'b1;
				s_axis_tdata  <= next_item.value;
			end
		end
	end

	// Receiver: one long hold-off so the chain fills, then random stalls, none in the second busy window.
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_axis_tready <= 1'b0;
			hold_left     <= 0;
			hold_done     <= 1'b0;
		end else if (!hold_done && accepted_values >= HOLD_AT) begin
			hold_done     <= 1'b1;
			hold_left     <= HOLD_CYCLES;
			m_axis_tready <= 1'b0;
		end else if (hold_left != 0) begin
			hold_left     <= hold_left - 1;
			m_axis_tready <= 1'b0;
		end else if (accepted_values >= BUSY_B_LO && accepted_values < BUSY_B_HI) begin
			m_axis_tready <= 1'b1;
		end else begin
			m_axis_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
		end
	end

	// Monitor: checks each character beat and expands each accepted value.
	always @(posedge clk or negedge arst_n) begin
		text_beat_t got;
		text_beat_t want;
		if (!arst_n) begin
			accepted_values <= 0;
			text_drained    <= 1'b1;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				got.code  = m_axis_tdata[CHAR_W-1:0];
				got.count = m_axis_tdata[CHAR_W+COUNT_W-1:CHAR_W];
				got.last  = m_axis_tlast;
				if (expected_text.size() == 0) begin
					$display("%0t: unexpected character beat %0d", $time, got.code);
					mismatches++;
				end else begin
					want = expected_text.pop_front();
					if (got.code !== want.code) begin
						$display("%0t: character expected %0d got %0d",
						         $time, want.code, got.code);
						mismatches++;
					end
					if (got.last !== want.last) begin
						$display("%0t: last expected %0b got %0b",
						         $time, want.last, got.last);
						mismatches++;
					end
					if (got.count !== want.count) begin
						$display("%0t: char_count expected %0d got %0d",
						         $time, want.count, got.count);
						mismatches++;
					end
				end
			end
			if (s_axis_tvalid && s_axis_tready) begin
				expand_decimal(s_axis_tdata);
				accepted_values <= accepted_values + 1;
			end
			text_drained <= (expected_text.size() == 0);
		end
	end

	// Watchdog: ends the run when neither stream moves for too long.
	always @(posedge clk) begin
		if (!arst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no beat for %0d cycles", $time, quiet_cycles);
			$display("RESULT: ERROR");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	// Stimulus and end of run.
	initial begin
		logic [IN_TDATA_W-1:0] directed [$];
		logic [31:0]           mag;
		longint unsigned       span;
		int                    pick;
		int                    n_digits;
		value_item_t           item;
		// Extremes, zero, the minimum value, powers of ten and bit patterns.
		directed = '{32'd0, 32'd1, 32'hFFFF_FFFF, 32'd9, -32'sd9, 32'd10, -32'sd10,
		             32'd99, 32'd100, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0001,
		             32'd1000000000, 32'd999999999, -32'sd1000000000, 32'd123456789,
		             -32'sd987654321, 32'h5555_5555, 32'hAAAA_AAAA, -32'sd100,
		             32'd4294967295};
		foreach (directed[i]) begin
			item.value       = directed[i];
			item.drain_first = 1'b0;
			value_queue.push_back(item);
		end
		for (int i = 0; i < RANDOM_VALUES; i++) begin
			pick = $urandom_range(0, 99);
			if (pick < 60) begin
				// Random digit count so every text length shows up often.
				n_digits = $urandom_range(1, NUM_DIGITS);
				span = 1;
				repeat (n_digits) span = span * 10;
				mag = 32'(longint'($urandom) % span);
				item.value = $urandom_range(0, 1) ? (32'd0 - mag) : mag;
			end else if (pick < 85) begin
				item.value = $urandom;
			end else if (pick < 93) begin
				mag = $urandom_range(0, 20);
				item.value = $urandom_range(0, 1) ? (32'd0 - mag) : mag;
			end else begin
				mag = $urandom_range(0, 20);
				item.value = $urandom_range(0, 1) ? (32'h7FFF_FFFF - mag) : (32'h8000_0000 + mag);
			end
			item.drain_first = (value_queue.size() == BUSY_A_HI ||
			                    value_queue.size() == BUSY_B_HI - 10);
			value_queue.push_back(item);
		end
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		do @(negedge clk);
		while (value_queue.size() != 0 || s_axis_tvalid || expected_text.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
		if (expected_text.size() != 0) begin
			$display("%0t: %0d character beats never arrived", $time, expected_text.size());
			mismatches++;
		end
		if (mismatches == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule

### sim.f
hw/rtl/i2da_pkg.sv
hw/rtl/i2da_cell.sv
hw/rtl/i2da_ser.sv
hw/rtl/int32_to_decimal_ascii_top.sv
tb/int32_to_decimal_ascii_top_test.sv
